### src/utfs_pkg.sv
`timescale 1ns / 1ps

package utfs_pkg;

   // FIFO geometry; one slot stays unused, so it holds FIFO_DEPTH-1 bytes
   localparam int FIFO_DEPTH = 64;
   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int LVL_CALC_W = (PTR_W + 1 > 6) ? PTR_W + 1 : 6;

   typedef logic [PTR_W-1:0] ptr_type;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_PUSH = 1'b1;

   localparam logic [1:0] PARITY_NONE = 2'd0;
   localparam logic [1:0] PARITY_ODD  = 2'd1;

   typedef enum logic [2:0] {
      CSR_DATA_BITS     = 3'd0,
      CSR_PARITY_MODE   = 3'd1,
      CSR_STOP_BITS     = 3'd2,
      CSR_INVERT        = 3'd3,
      CSR_TICKS_PER_BIT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic       tx_line;
      logic       busy_res;
      logic       dropped;
      logic [5:0] fifo_level;
   } rsp_type;

   function automatic ptr_type wrap_next(input ptr_type idx);
      if (idx == PTR_W'(FIFO_DEPTH - 1)) begin
         return '0;
      end
      return idx + ptr_type'(1);
   endfunction

endpackage

### src/utfs_fifo_mem.sv
`timescale 1ns / 1ps

module utfs_fifo_mem
   import utfs_pkg::*;
(
   input  logic       clock,
   input  logic       wr_en,
   input  ptr_type    wr_addr,
   input  logic [7:0] wr_data,
   input  ptr_type    rd_addr,
   output logic [7:0] rd_data
);

   logic [7:0] store_ff [FIFO_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // write-first: a byte landing on the slot being read shows up at once
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/utfs_rsp_skid.sv
`timescale 1ns / 1ps

module utfs_rsp_skid
   import utfs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    in_stall,
   output logic    out_valid,
   input  logic    out_stall,
   output rsp_type out_data
);

   logic    out_valid_ff;
   logic    skid_valid_ff;
   rsp_type out_ff;
   rsp_type skid_ff;
   logic    out_take;

   assign out_take = out_valid_ff && !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (in_valid) begin
         if (!out_valid_ff || out_take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         if (!out_valid_ff || out_take) begin
            out_ff <= in_data;
         end else begin
            skid_ff <= in_data;
         end
      end else if (out_take && skid_valid_ff) begin
         out_ff <= skid_ff;
      end
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

### src/uart_tx_fifo_serializer_core.sv
`timescale 1ns / 1ps

// UART transmitter with a circular byte FIFO.
// req channel: one beat per item. req_op selects a timer tick or a byte push
// (req_data). Every accepted beat yields exactly one rsp beat carrying the
// line level, busy flag, overflow flag and FIFO fill level after that item.
// Throughput: one item per clock while req_stall is low. Each item updates
// the tick counter, the frame sequencer and the FIFO pointers in the cycle
// it is accepted; the result is registered and offered on rsp.
// The next byte of a frame is prefetched from the FIFO store every cycle,
// so a back-to-back frame start need not wait for a read.
// When rsp_stall is high, one more result parks in a skid register; req_stall
// rises only once both output registers are full, and drops as soon as the
// receiver takes a beat.
// csr channel: register writes by index (0 data_bits, 1 parity_mode,
// 2 stop_bits, 3 invert, 4 ticks_per_bit), csr_ready is always high. Write
// only while idle. Writing invert while no frame runs moves the line to the
// new idle level at once.
// Reset (synchronous): FIFO empty, transmitter idle, line at mark, registers
// at 8 data bits, no parity, 1 stop bit, no inversion, 312 ticks per bit.
// FIFO contents are not cleared; there is no clearing pass.

module uart_tx_fifo_serializer_core
   import utfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_data,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_tx_line,
   output logic        rsp_busy_res,
   output logic        rsp_dropped,
   output logic [5:0]  rsp_fifo_level,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   // configuration
   logic [3:0]  data_bits_ff, data_bits_in;
   logic [1:0]  parity_mode_ff, parity_mode_in;
   logic [1:0]  stop_bits_ff, stop_bits_in;
   logic        invert_ff, invert_in;
   logic [15:0] ticks_per_bit_ff, ticks_per_bit_in;

   // transmitter state
   ptr_type     head_ff, head_in;
   ptr_type     tail_ff, tail_in;
   logic [7:0]  shift_ff, shift_in;
   logic [3:0]  phase_ff, phase_in;
   logic [16:0] tick_ff, tick_in;
   logic        parity_ff, parity_in;
   logic        sending_ff, sending_in;
   logic        line_ff, line_in;

   logic        accept;
   logic        csr_wr;
   logic        wr_en;
   ptr_type     push_slot;
   ptr_type     tail_next;
   logic [7:0]  prefetch;
   logic        dropped;
   logic        start;
   logic [7:0]  start_byte;
   logic [7:0]  frame_byte;
   logic [3:0]  eff_bits;
   logic [3:0]  eff_bits_p1;
   logic [16:0] bit_ticks;
   logic [16:0] stop_ticks;
   logic        parity_en;
   logic [7:0]  bit_mask;
   logic [PTR_W:0]      level_full;
   logic [LVL_CALC_W-1:0] level_ext;
   rsp_type     rsp_next;
   rsp_type     rsp_out;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign accept    = req_valid && !req_stall;

   // effective register values
   assign eff_bits    = (data_bits_ff > 4'd8) ? 4'd8 : data_bits_ff;
   assign eff_bits_p1 = eff_bits + 4'd1;
   assign bit_ticks   = (ticks_per_bit_ff == 16'd0) ? 17'd1 : {1'b0, ticks_per_bit_ff};
   assign stop_ticks  = (stop_bits_ff >= 2'd2) ? {bit_ticks[15:0], 1'b0} : bit_ticks;
   assign parity_en   = (parity_mode_ff != PARITY_NONE);
   assign bit_mask    = ~(8'hFF << eff_bits);

   assign push_slot = wrap_next(head_ff);
   assign tail_next = wrap_next(tail_ff);

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      shift_in   = shift_ff;
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      parity_in  = parity_ff;
      sending_in = sending_ff;
      line_in    = line_ff;
      wr_en      = 1'b0;
      dropped    = 1'b0;
      start      = 1'b0;
      start_byte = prefetch;

      if (accept) begin
         if (req_op == OP_PUSH) begin
            if (push_slot != tail_ff) begin
               wr_en   = 1'b1;
               head_in = push_slot;
            end else begin
               dropped = 1'b1;
            end
            if (!sending_ff && (tail_ff != head_in)) begin
               start = 1'b1;
               // the slot just written is the one the frame takes
               if (wr_en && (push_slot == tail_next)) begin
                  start_byte = req_data;
               end
            end
         end else if (sending_ff) begin
            if (tick_ff > 17'd1) begin
               tick_in = tick_ff - 17'd1;
            end else if (phase_ff < eff_bits) begin
               line_in  = shift_ff[0];
               shift_in = {1'b0, shift_ff[7:1]};
               phase_in = phase_ff + 4'd1;
               tick_in  = bit_ticks;
            end else if (phase_ff == eff_bits) begin
               if (parity_en) begin
                  line_in = parity_ff;
                  tick_in = bit_ticks;
               end else begin
                  line_in = ~invert_ff;
                  tick_in = stop_ticks;
               end
               phase_in = phase_ff + 4'd1;
            end else if ((phase_ff == eff_bits_p1) && parity_en) begin
               line_in  = ~invert_ff;
               tick_in  = stop_ticks;
               phase_in = phase_ff + 4'd1;
            end else if (tail_ff == head_ff) begin
               sending_in = 1'b0;
            end else begin
               start = 1'b1;
            end
         end
      end

      frame_byte = invert_ff ? ~start_byte : start_byte;
      if (start) begin
         tail_in  = tail_next;
         shift_in = frame_byte;
         if (parity_en) begin
            // odd parity sets the bit when the count of ones is even
            if (parity_mode_ff == PARITY_ODD) begin
               parity_in = ~(^(frame_byte & bit_mask));
            end else begin
               parity_in = ^(frame_byte & bit_mask);
            end
         end
         phase_in   = 4'd0;
         tick_in    = bit_ticks;
         line_in    = invert_ff;
         sending_in = 1'b1;
      end

      // an idle line follows the new polarity right away
      if (csr_wr && (csr_index_type'(csr_index) == CSR_INVERT) && !sending_ff) begin
         line_in = ~csr_data[0];
      end
   end

   always_comb begin
      data_bits_in     = data_bits_ff;
      parity_mode_in   = parity_mode_ff;
      stop_bits_in     = stop_bits_ff;
      invert_in        = invert_ff;
      ticks_per_bit_in = ticks_per_bit_ff;
      if (csr_wr) begin
         unique case (csr_index_type'(csr_index))
            CSR_DATA_BITS:     data_bits_in     = csr_data[3:0];
            CSR_PARITY_MODE:   parity_mode_in   = csr_data[1:0];
            CSR_STOP_BITS:     stop_bits_in     = csr_data[1:0];
            CSR_INVERT:        invert_in        = csr_data[0];
            CSR_TICKS_PER_BIT: ticks_per_bit_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_bits_ff     <= 4'd8;
         parity_mode_ff   <= PARITY_NONE;
         stop_bits_ff     <= 2'd1;
         invert_ff        <= 1'b0;
         ticks_per_bit_ff <= 16'd312;
         head_ff          <= '0;
         tail_ff          <= '0;
         shift_ff         <= 8'd0;
         phase_ff         <= 4'd0;
         tick_ff          <= 17'd0;
         parity_ff        <= 1'b0;
         sending_ff       <= 1'b0;
         line_ff          <= 1'b1;
      end else begin
         data_bits_ff     <= data_bits_in;
         parity_mode_ff   <= parity_mode_in;
         stop_bits_ff     <= stop_bits_in;
         invert_ff        <= invert_in;
         ticks_per_bit_ff <= ticks_per_bit_in;
         head_ff          <= head_in;
         tail_ff          <= tail_in;
         shift_ff         <= shift_in;
         phase_ff         <= phase_in;
         tick_ff          <= tick_in;
         parity_ff        <= parity_in;
         sending_ff       <= sending_in;
         line_ff          <= line_in;
      end
   end

   // fill level after this item, modulo the ring size
   always_comb begin
      if (head_in >= tail_in) begin
         level_full = {1'b0, head_in} - {1'b0, tail_in};
      end else begin
         level_full = {1'b0, head_in} + (PTR_W + 1)'(FIFO_DEPTH) - {1'b0, tail_in};
      end
      level_ext = LVL_CALC_W'(level_full);
   end

   assign rsp_next.tx_line    = line_in;
   assign rsp_next.busy_res   = sending_in;
   assign rsp_next.dropped    = dropped;
   assign rsp_next.fifo_level = level_ext[5:0];

   // prefetch always holds the slot after the next tail
   utfs_fifo_mem u_fifo (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (push_slot),
      .wr_data (req_data),
      .rd_addr (wrap_next(tail_in)),
      .rd_data (prefetch)
   );

   utfs_rsp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (rsp_next),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_out)
   );

   assign rsp_tx_line    = rsp_out.tx_line;
   assign rsp_busy_res   = rsp_out.busy_res;
   assign rsp_dropped    = rsp_out.dropped;
   assign rsp_fifo_level = rsp_out.fifo_level;

endmodule
